### src/wrax_pkg.sv
package wrax_pkg;

  localparam logic [5:0] OP_ADD   = 6'd0;
  localparam logic [5:0] OP_SUB   = 6'd1;
  localparam logic [5:0] OP_CMP   = 6'd2;
  localparam logic [5:0] OP_AND   = 6'd3;
  localparam logic [5:0] OP_OR    = 6'd4;
  localparam logic [5:0] OP_XOR   = 6'd5;
  localparam logic [5:0] OP_NOT   = 6'd6;
  localparam logic [5:0] OP_LSL   = 6'd7;
  localparam logic [5:0] OP_LSR   = 6'd8;
  localparam logic [5:0] OP_ROL   = 6'd9;
  localparam logic [5:0] OP_ROR   = 6'd10;
  localparam logic [5:0] OP_ROL8  = 6'd11;
  localparam logic [5:0] OP_ROR8  = 6'd12;
  localparam logic [5:0] OP_SWE   = 6'd13;
  localparam logic [5:0] OP_MOV   = 6'd14;
  localparam logic [5:0] OP_CSWAP = 6'd15;
  localparam logic [5:0] OP_SCB   = 6'd16;
  localparam logic [5:0] OP_M25519 = 6'd17;
  localparam logic [5:0] OP_M256  = 6'd18;
  localparam logic [5:0] OP_ADDP  = 6'd19;
  localparam logic [5:0] OP_SUBP  = 6'd20;
  localparam logic [5:0] OP_MULP  = 6'd21;
  localparam logic [5:0] OP_REDP  = 6'd22;
  localparam logic [5:0] OP_ADDI  = 6'd23;
  localparam logic [5:0] OP_SUBI  = 6'd24;
  localparam logic [5:0] OP_CMPI  = 6'd25;
  localparam logic [5:0] OP_ANDI  = 6'd26;
  localparam logic [5:0] OP_ORI   = 6'd27;
  localparam logic [5:0] OP_XORI  = 6'd28;
  localparam logic [5:0] OP_CMPA  = 6'd29;
  localparam logic [5:0] OP_MOVI  = 6'd30;
  localparam logic [5:0] OP_LDL   = 6'd31;
  localparam logic [5:0] OP_ST    = 6'd32;

  typedef logic [255:0] word_t;

  localparam word_t P25519 =
    256'h7FFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFED;
  localparam word_t P256 =
    256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;
  localparam word_t SCB_BITS =
    256'h8000000080000000_0000000000000000_0000000000000000_0000000000000000;

  function automatic word_t swap_bytes(input word_t v);
    word_t r;
    for (int i = 0; i < 32; i++) begin
      r[8*i +: 8] = v[8*(31-i) +: 8];
    end
    return r;
  endfunction

endpackage

### src/wide_register_alu_execute.sv
// channel  direction  signals
// in       input      in_valid, in_ready, operation .. load_limb
// out      output     out_valid, out_ready, reg_index .. last
//
// one instruction at a time: A, B, R31 and D are read limb by limb; then ADDP,
// SUBP and REDP use the 512-step serial reduction, multiplies use the 256-step
// shift-add multiplier and then the reduction, SCB the multiplier and an add of A,
// and results go out at one cycle per result transfer while out_ready is high.
// reset clears flags and the per-limb valid bits; registers read as zero
// until written. out stalls hold the block; in_ready is high only when idle
module wide_register_alu_execute import wrax_pkg::*; #(
  parameter int NUM_REGS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  operation,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_a_reg,
  input  logic [4:0]  src_b_reg,
  input  logic [11:0] immediate,
  input  logic [63:0] load_value,
  input  logic [1:0]  load_limb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  reg_index,
  output logic [1:0]  limb_index,
  output logic [63:0] limb_value,
  output logic        reg_written,
  output logic        zero_flag,
  output logic        carry_flag,
  output logic        last
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = RW + 2;
  localparam int DEPTH = NUM_REGS * 4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SCBL  = 4'd4;
  localparam logic [3:0] S_SCBH  = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_SUB   = 4'd7;
  localparam logic [3:0] S_MOD   = 4'd8;
  localparam logic [3:0] S_MODE  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_DRAIN = 4'd11;

  logic [3:0] state;

  logic [63:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [63:0] rdata;
  logic rvld;
  logic rd_en_q;
  logic [1:0] rd_grp_q;

  logic [5:0] op_q;
  logic [RW-1:0] dreg, sa, sb;
  logic [11:0] imm_q;
  logic [63:0] lval_q;
  logic [1:0] llimb_q;

  word_t a_q, b_q, p_q, d_q, mm_q, r_q;
  logic [511:0] x_q, s_q;
  logic sc_q;
  logic [4:0] rcnt;
  logic [8:0] cnt;
  logic [2:0] ecnt;
  logic [1:0] nregs;
  logic fo_q;
  logic [RW-1:0] w0, w1;
  logic zero_q, carry_q;

  logic out_valid_q, out_wr_q, out_last_q;
  logic [RW-1:0] out_reg_q;
  logic [1:0] out_limb_q;
  logic [63:0] out_val_q;

  logic [AW-1:0] raddr, waddr;
  logic rd_en, wr_en, e_load;
  logic [RW-1:0] rreg, e_reg;
  logic [63:0] rval;
  logic [2:0] last_idx;

  word_t mcand, mnext;
  logic [256:0] msum, mcur, lsum;
  logic [257:0] mdiff, sdiff;

  word_t ex_res0, ex_res1;
  logic [1:0] ex_nregs;
  logic ex_fo, ex_zupd, ex_z, ex_cupd, ex_c;
  logic [RW-1:0] ex_w1;
  logic [31:0] rhs32, v32;
  logic is_imm;

  always_comb begin
    unique case (rcnt[3:2])
      2'd0: rreg = sa;
      2'd1: rreg = sb;
      2'd2: rreg = RW'(NUM_REGS - 1);
      default: rreg = dreg;
    endcase
  end

  assign raddr = {rreg, rcnt[1:0]};
  assign rd_en = (state == S_READ) && !rcnt[4];
  assign rval = rvld ? rdata : 64'd0;

  assign e_reg = ecnt[2] ? w1 : w0;
  assign e_load = (state == S_EMIT) && (!out_valid_q || out_ready);
  assign wr_en = e_load && !fo_q;
  assign waddr = {e_reg, ecnt[1:0]};
  assign last_idx = fo_q ? 3'd0 : (nregs == 2'd2 ? 3'd7 : 3'd3);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= s_q[63:0];
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rvld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rvld <= vld[raddr];
      end
    end
  end

  // serial multiplier and reducer
  assign mcand = (op_q == OP_SCB) ? p_q : a_q;
  assign msum = {1'b0, x_q[511:256]} + (x_q[0] ? {1'b0, mcand} : 257'd0);
  assign mcur = {r_q, x_q[511]};
  assign mdiff = {1'b0, mcur} - {2'b00, mm_q};
  assign mnext = mdiff[257] ? mcur[255:0] : mdiff[255:0];
  assign lsum = {1'b0, a_q} + ((op_q == OP_ADDP) ? {1'b0, b_q} :
                (a_q < b_q) ? {1'b0, p_q} : 257'd0);
  assign sdiff = {1'b0, x_q[256:0]} - {2'b00, b_q};

  assign is_imm = (op_q == OP_ADDI) || (op_q == OP_SUBI) || (op_q == OP_CMPI) ||
                  (op_q == OP_ANDI) || (op_q == OP_ORI) || (op_q == OP_XORI);
  assign rhs32 = is_imm ? {20'd0, imm_q} : b_q[31:0];

  always_comb begin
    ex_res0 = '0;
    ex_res1 = '0;
    ex_nregs = 2'd1;
    ex_fo = 1'b0;
    ex_zupd = 1'b0;
    ex_z = 1'b0;
    ex_cupd = 1'b0;
    ex_c = 1'b0;
    ex_w1 = sa;
    v32 = '0;
    unique case (op_q) inside
      OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_CMP, OP_CMPI: begin
        v32 = (op_q == OP_ADD || op_q == OP_ADDI) ? a_q[31:0] + rhs32
                                                   : a_q[31:0] - rhs32;
        ex_zupd = 1'b1;
        ex_z = (v32 == 32'd0);
        ex_res0 = {224'd0, v32};
        ex_fo = (op_q == OP_CMP) || (op_q == OP_CMPI);
      end
      OP_AND, OP_ANDI: v32 = a_q[31:0] & rhs32;
      OP_OR, OP_ORI: v32 = a_q[31:0] | rhs32;
      OP_XOR, OP_XORI: v32 = a_q[31:0] ^ rhs32;
      OP_NOT: v32 = ~a_q[31:0];
      OP_LSL: begin
        ex_cupd = 1'b1;
        ex_c = a_q[255];
        ex_res0 = {a_q[254:0], 1'b0};
      end
      OP_ROL: begin
        ex_cupd = 1'b1;
        ex_c = a_q[255];
        ex_res0 = {a_q[254:0], a_q[255]};
      end
      OP_LSR: begin
        ex_cupd = 1'b1;
        ex_c = a_q[0];
        ex_res0 = {1'b0, a_q[255:1]};
      end
      OP_ROR: begin
        ex_cupd = 1'b1;
        ex_c = a_q[0];
        ex_res0 = {a_q[0], a_q[255:1]};
      end
      OP_ROL8: ex_res0 = {a_q[247:0], a_q[255:248]};
      OP_ROR8: ex_res0 = {a_q[7:0], a_q[255:8]};
      OP_SWE: ex_res0 = swap_bytes(a_q);
      OP_MOV: ex_res0 = a_q;
      OP_CSWAP: begin
        ex_res0 = carry_q ? a_q : d_q;
        ex_res1 = carry_q ? d_q : a_q;
        ex_nregs = (dreg == sa) ? 2'd1 : 2'd2;
      end
      OP_CMPA: begin
        ex_zupd = 1'b1;
        ex_z = (a_q == {244'd0, imm_q});
        ex_fo = 1'b1;
      end
      OP_MOVI: ex_res0 = {244'd0, imm_q};
      OP_LDL: begin
        ex_res0 = d_q;
        ex_res0[64*llimb_q +: 64] = lval_q;
      end
      default: ex_res0 = d_q;
    endcase
    if (op_q == OP_AND || op_q == OP_OR || op_q == OP_XOR || op_q == OP_NOT) begin
      ex_res0 = {a_q[255:32], v32};
      ex_zupd = 1'b1;
      ex_z = (v32 == 32'd0);
    end else if (op_q == OP_ANDI || op_q == OP_ORI || op_q == OP_XORI) begin
      ex_res0 = {a_q[255:12], v32[11:0]};
      ex_zupd = 1'b1;
      ex_z = ({a_q[31:12], v32[11:0]} == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_en_q <= 1'b0;
      zero_q <= 1'b0;
      carry_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_en_q <= rd_en;
      rd_grp_q <= rcnt[3:2];
      if (e_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      if (rd_en_q) begin
        unique case (rd_grp_q)
          2'd0: a_q <= {rval, a_q[255:64]};
          2'd1: b_q <= {rval, b_q[255:64]};
          2'd2: p_q <= {rval, p_q[255:64]};
          default: d_q <= {rval, d_q[255:64]};
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && operation <= OP_ST) begin
            op_q <= operation;
            dreg <= dest_reg[RW-1:0];
            sa <= src_a_reg[RW-1:0];
            sb <= src_b_reg[RW-1:0];
            imm_q <= immediate;
            lval_q <= load_value;
            llimb_q <= load_limb;
            rcnt <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          rcnt <= rcnt + 5'd1;
          if (rcnt[4]) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          cnt <= '0;
          r_q <= '0;
          mm_q <= (op_q == OP_M25519) ? P25519 : (op_q == OP_M256) ? P256 : p_q;
          ecnt <= '0;
          w0 <= dreg;
          unique case (op_q) inside
            OP_M25519, OP_M256, OP_MULP: begin
              x_q <= {256'd0, b_q};
              state <= S_MUL;
            end
            OP_SCB: begin
              x_q <= {256'd0, b_q | SCB_BITS};
              state <= S_MUL;
            end
            OP_ADDP, OP_SUBP: state <= S_ADD;
            OP_REDP: begin
              x_q <= {a_q, b_q};
              state <= S_MOD;
            end
            default: begin
              s_q <= {ex_res1, ex_res0};
              nregs <= ex_nregs;
              fo_q <= ex_fo;
              w1 <= ex_w1;
              if (ex_zupd) zero_q <= ex_z;
              if (ex_cupd) carry_q <= ex_c;
              state <= S_EMIT;
            end
          endcase
        end
        S_MUL: begin
          x_q <= {msum, x_q[255:1]};
          if (cnt == 9'd255) begin
            cnt <= '0;
            state <= (op_q == OP_SCB) ? S_SCBL : S_MOD;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        S_SCBL: begin
          {sc_q, x_q[255:0]} <= {1'b0, x_q[255:0]} + {1'b0, a_q};
          state <= S_SCBH;
        end
        S_SCBH: begin
          s_q <= {x_q[511:256] + {255'd0, sc_q}, x_q[255:0]};
          w1 <= dreg + RW'(1);
          nregs <= 2'd2;
          fo_q <= 1'b0;
          state <= S_EMIT;
        end
        S_ADD: begin
          x_q <= {255'd0, lsum};
          state <= (op_q == OP_ADDP) ? S_MOD : S_SUB;
        end
        S_SUB: begin
          x_q <= {{254{sdiff[257]}}, sdiff};
          state <= S_MOD;
        end
        S_MOD: begin
          r_q <= mnext;
          x_q <= {x_q[510:0], 1'b0};
          cnt <= cnt + 9'd1;
          if (cnt == 9'd511) begin
            state <= S_MODE;
          end
        end
        S_MODE: begin
          s_q <= {256'd0, (mm_q == '0) ? 256'd0 : r_q};
          nregs <= 2'd1;
          fo_q <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (e_load) begin
            out_reg_q <= fo_q ? '0 : e_reg;
            out_limb_q <= fo_q ? 2'd0 : ecnt[1:0];
            out_val_q <= fo_q ? 64'd0 : s_q[63:0];
            out_wr_q <= !fo_q;
            out_last_q <= (ecnt == last_idx);
            s_q <= {64'd0, s_q[511:64]};
            ecnt <= ecnt + 3'd1;
            if (ecnt == last_idx) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = out_valid_q;
  assign reg_index = 5'(out_reg_q);
  assign limb_index = out_limb_q;
  assign limb_value = out_val_q;
  assign reg_written = out_wr_q;
  assign zero_flag = zero_q;
  assign carry_flag = carry_q;
  assign last = out_last_q;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import wrax_pkg::*; ();

  typedef struct {
    logic [5:0]  op;
    logic [4:0]  d;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [11:0] imm;
    logic [63:0] lval;
    logic [1:0]  llimb;
    bit          drain;
  } instr_t;

  typedef struct {
    logic [4:0]  ri;
    logic [1:0]  li;
    logic [63:0] lv;
    logic        rw;
    logic        z;
    logic        c;
    logic        lst;
  } limb_res_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_RANDOM = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  operation = '0;
  logic [4:0]  dest_reg = '0;
  logic [4:0]  src_a_reg = '0;
  logic [4:0]  src_b_reg = '0;
  logic [11:0] immediate = '0;
  logic [63:0] load_value = '0;
  logic [1:0]  load_limb = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  reg_index;
  logic [1:0]  limb_index;
  logic [63:0] limb_value;
  logic        reg_written;
  logic        zero_flag;
  logic        carry_flag;
  logic        last;

  wide_register_alu_execute uut (.*);

  instr_t    pend_q[$];
  limb_res_t want_q[$];
  instr_t    cur;

  logic [255:0] regfile[32];
  logic         z_bit;
  logic         c_bit;

  int n_instr = 0;
  int n_results = 0;
  int n_modular = 0;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit held_once = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [255:0] mod_of(input logic [511:0] x, input logic [255:0] m);
    if (m == '0) return '0;
    return 256'(x % {256'b0, m});
  endfunction

  function automatic logic [255:0] byte_reverse(input logic [255:0] v);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) r[8*i +: 8] = v[8*(31-i) +: 8];
    return r;
  endfunction

  task automatic report_reg(inout limb_res_t q[$], input logic [4:0] r);
    limb_res_t e;
    for (int k = 0; k < 4; k++) begin
      e.ri = r;
      e.li = 2'(k);
      e.lv = regfile[r][64*k +: 64];
      e.rw = 1'b1;
      q.push_back(e);
    end
  endtask

  // updates the register file and flags, queues the limbs this instruction reports
  task automatic execute_instr(input instr_t it);
    limb_res_t    out_q[$];
    limb_res_t    e;
    logic [255:0] a, b, p, r, dv;
    logic [511:0] t;
    logic [63:0]  rhs, v, m;
    bit           flag_only;
    a = regfile[it.a];
    b = regfile[it.b];
    p = regfile[31];
    r = '0;
    flag_only = 0;
    case (it.op)
      OP_ADD, OP_SUB, OP_CMP, OP_ADDI, OP_SUBI, OP_CMPI: begin
        rhs = (it.op >= OP_ADDI) ? 64'(it.imm) : b[63:0];
        v = (it.op == OP_ADD || it.op == OP_ADDI) ? a[63:0] + rhs : a[63:0] - rhs;
        v = v & 64'hFFFFFFFF;
        z_bit = (v == 0);
        if (it.op == OP_CMP || it.op == OP_CMPI) begin
          flag_only = 1;
        end else begin
          regfile[it.d] = {192'b0, v};
          report_reg(out_q, it.d);
        end
      end
      OP_AND, OP_OR, OP_XOR, OP_NOT, OP_ANDI, OP_ORI, OP_XORI: begin
        m = (it.op >= OP_ANDI) ? 64'hFFF : 64'hFFFFFFFF;
        rhs = (it.op >= OP_ANDI) ? 64'(it.imm) : b[63:0];
        if (it.op == OP_AND || it.op == OP_ANDI) v = a[63:0] & rhs;
        else if (it.op == OP_OR || it.op == OP_ORI) v = a[63:0] | rhs;
        else if (it.op == OP_XOR || it.op == OP_XORI) v = a[63:0] ^ rhs;
        else v = ~a[63:0];
        r = a;
        r[63:0] = (a[63:0] & ~m) | (v & m);
        z_bit = (r[31:0] == 0);
        regfile[it.d] = r;
        report_reg(out_q, it.d);
      end
      OP_LSL, OP_ROL, OP_LSR, OP_ROR, OP_ROL8, OP_ROR8, OP_SWE, OP_MOV: begin
        case (it.op)
          OP_LSL: begin c_bit = a[255]; r = a << 1; end
          OP_ROL: begin c_bit = a[255]; r = {a[254:0], a[255]}; end
          OP_LSR: begin c_bit = a[0]; r = a >> 1; end
          OP_ROR: begin c_bit = a[0]; r = {a[0], a[255:1]}; end
          OP_ROL8: r = {a[247:0], a[255:248]};
          OP_ROR8: r = {a[7:0], a[255:8]};
          OP_SWE: r = byte_reverse(a);
          default: r = a;
        endcase
        regfile[it.d] = r;
        report_reg(out_q, it.d);
      end
      OP_CSWAP: begin
        dv = regfile[it.d];
        if (c_bit) begin
          regfile[it.a] = dv;
          regfile[it.d] = a;
        end
        report_reg(out_q, it.d);
        if (it.a != it.d) report_reg(out_q, it.a);
      end
      OP_SCB: begin
        t = {256'b0, b | SCB_BITS} * {256'b0, p} + {256'b0, a};
        regfile[it.d] = t[255:0];
        regfile[5'(it.d + 1)] = t[511:256];
        report_reg(out_q, it.d);
        report_reg(out_q, 5'(it.d + 1));
      end
      OP_M25519, OP_M256, OP_MULP, OP_ADDP, OP_SUBP, OP_REDP: begin
        case (it.op)
          OP_M25519: r = mod_of({256'b0, a} * {256'b0, b}, P25519);
          OP_M256:   r = mod_of({256'b0, a} * {256'b0, b}, P256);
          OP_MULP:   r = mod_of({256'b0, a} * {256'b0, b}, p);
          OP_ADDP:   r = mod_of({256'b0, a} + {256'b0, b}, p);
          OP_SUBP: begin
            t = {256'b0, a};
            if (b > a) t = t + {256'b0, p};
            r = mod_of(t - {256'b0, b}, p);
          end
          default:   r = mod_of({a, b}, p);
        endcase
        regfile[it.d] = r;
        report_reg(out_q, it.d);
      end
      OP_CMPA: begin
        z_bit = (a == {244'b0, it.imm});
        flag_only = 1;
      end
      OP_MOVI: begin
        regfile[it.d] = {244'b0, it.imm};
        report_reg(out_q, it.d);
      end
      OP_LDL: begin
        regfile[it.d][64*it.llimb +: 64] = it.lval;
        report_reg(out_q, it.d);
      end
      OP_ST: report_reg(out_q, it.d);
      default: ;
    endcase
    if (flag_only) begin
      e.ri = '0;
      e.li = '0;
      e.lv = '0;
      e.rw = 1'b0;
      out_q.push_back(e);
    end
    foreach (out_q[k]) begin
      out_q[k].z = z_bit;
      out_q[k].c = c_bit;
      out_q[k].lst = (k == out_q.size() - 1);
      want_q.push_back(out_q[k]);
    end
  endtask

  task automatic add_instr(input logic [5:0] op, input logic [4:0] d, input logic [4:0] a,
                           input logic [4:0] b, input logic [11:0] imm,
                           input logic [63:0] lval, input logic [1:0] ll, input bit drain);
    instr_t it;
    it.op = op;
    it.d = d;
    it.a = a;
    it.b = b;
    it.imm = imm;
    it.lval = lval;
    it.llimb = ll;
    it.drain = drain;
    pend_q.push_back(it);
  endtask

  function automatic logic [63:0] rand_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000000000000000;
      3: return 64'(1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    bit busy;
    busy = in_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        execute_instr(cur);
        n_instr++;
        if (cur.op >= OP_M25519 && cur.op <= OP_REDP) n_modular++;
        busy = 0;
        if (pend_q.size() > 60 && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 4);
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && want_q.size() != 0)) begin
          cur = pend_q.pop_front();
          busy = 1;
          operation <= cur.op;
          dest_reg <= cur.d;
          src_a_reg <= cur.a;
          src_b_reg <= cur.b;
          immediate <= cur.imm;
          load_value <= cur.lval;
          load_limb <= cur.llimb;
        end
      end
      in_valid <= busy;
    end
  end

  // monitor
  always @(posedge clk) begin
    limb_res_t e;
    bit rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: reg %0d limb %0d value %h", reg_index, limb_index,
                     limb_value);
        end else begin
          e = want_q.pop_front();
          if (reg_index !== e.ri || limb_index !== e.li || limb_value !== e.lv ||
              reg_written !== e.rw || zero_flag !== e.z || carry_flag !== e.c ||
              last !== e.lst) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp reg %0d limb %0d %h w%b z%b c%b l%b",
                       e.ri, e.li, e.lv, e.rw, e.z, e.c, e.lst);
              $display("          got reg %0d limb %0d %h w%b z%b c%b l%b",
                       reg_index, limb_index, limb_value, reg_written, zero_flag,
                       carry_flag, last);
            end
          end
        end
      end
      rdy = 1;
      if (!held_once && n_results >= 120) begin
        held_once = 1;
        out_gap = 300;
      end
      if (out_gap > 0) begin
        out_gap--;
        rdy = 0;
      end else if (pend_q.size() > 60 && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 3);
        rdy = 0;
      end
      out_ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending", IDLE_LIMIT,
               want_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [5:0] op;
    for (int i = 0; i < 32; i++) regfile[i] = '0;
    z_bit = 0;
    c_bit = 0;
    // directed
    for (int k = 0; k < 4; k++) add_instr(OP_LDL, 1, 0, 0, 0, '1, 2'(k), 0);
    add_instr(OP_LDL, 2, 0, 0, 0, 64'd1, 0, 0);
    add_instr(OP_ADD, 3, 1, 2, 0, 0, 0, 0);
    add_instr(OP_CMP, 0, 2, 2, 0, 0, 0, 0);
    add_instr(OP_ADDP, 4, 1, 2, 0, 0, 0, 0);
    add_instr(OP_MULP, 4, 1, 1, 0, 0, 0, 0);
    add_instr(OP_LDL, 31, 0, 0, 0, 64'hFFFFFFFFFFFFFFC5, 0, 0);
    add_instr(OP_M25519, 5, 1, 1, 0, 0, 0, 0);
    add_instr(OP_M256, 6, 1, 1, 0, 0, 0, 0);
    add_instr(OP_MULP, 7, 1, 1, 0, 0, 0, 0);
    add_instr(OP_SUBP, 8, 2, 1, 0, 0, 0, 0);
    add_instr(OP_REDP, 9, 1, 1, 0, 0, 0, 0);
    add_instr(OP_SCB, 31, 1, 1, 0, 0, 0, 0);
    add_instr(OP_LSL, 10, 1, 0, 0, 0, 0, 0);
    add_instr(OP_CSWAP, 10, 10, 0, 0, 0, 0, 0);
    add_instr(OP_CSWAP, 11, 1, 0, 0, 0, 0, 0);
    add_instr(OP_ROR, 12, 2, 0, 0, 0, 0, 0);
    add_instr(OP_SWE, 13, 5, 0, 0, 0, 0, 0);
    add_instr(OP_CMPA, 0, 2, 0, 12'd1, 0, 0, 0);
    add_instr(OP_MOVI, 14, 0, 0, 12'hFFF, 0, 0, 0);
    add_instr(OP_XORI, 15, 1, 0, 12'hFFF, 0, 0, 0);
    add_instr(OP_ST, 31, 0, 0, 0, 0, 0, 0);
    add_instr(6'd63, 0, 0, 0, 0, 0, 0, 0);
    // random
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1: op = OP_LDL;
        2: op = 6'($urandom_range(33, 63));
        default: op = 6'($urandom_range(0, 32));
      endcase
      add_instr(op, 5'($urandom), 5'($urandom), 5'($urandom),
                ($urandom_range(0, 5) == 0) ? 12'hFFF : 12'($urandom), rand_limb(),
                2'($urandom), i == 0 || i == 240);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("%0d instructions executed (%0d modular), %0d result transfers checked",
             n_instr, n_modular, n_results);
    if (errors == 0 && want_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
